// File: sv/foccl_pkg.sv
// ----------------------------------------------------------------------------
// FOC current loop package
// Constants and shared types for the field-oriented current loop.
// ----------------------------------------------------------------------------
package foccl_pkg;

   localparam int B_WIDTH = 18;

   localparam logic [1:0] CSR_Q_PROP  = 2'd0;
   localparam logic [1:0] CSR_Q_INTEG = 2'd1;
   localparam logic [1:0] CSR_D_PROP  = 2'd2;
   localparam logic [1:0] CSR_D_INTEG = 2'd3;

   localparam logic [15:0] SIN_A          = 16'd25736;
   localparam logic [15:0] SIN_B          = 16'd10512;
   localparam logic [15:0] SIN_C          = 16'd1160;
   localparam logic [15:0] INV_SQRT3_Q15  = 16'd18918;
   localparam logic [15:0] SQRT3_HALF_Q15 = 16'd28378;
   localparam logic [15:0] HALF_Q15       = 16'd16384;
   localparam logic [15:0] QUARTER_TURN   = 16'd16384;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic use_acc;
      logic negate;
   } mac_ctl_type;

endpackage

// File: sv/foccl_mac.sv
// ----------------------------------------------------------------------------
// FOC current loop multiply-accumulate unit
// One registered signed multiplier followed by an add or subtract stage.
// ----------------------------------------------------------------------------
module foccl_mac #(
   parameter int A_WIDTH   = 36,
   parameter int ACC_WIDTH = 56
) (
   input  logic                        clock,
   input  foccl_pkg::mac_ctl_type      ctl,
   input  logic signed [A_WIDTH-1:0]   op_a,
   input  logic signed [foccl_pkg::B_WIDTH-1:0] op_b,
   input  logic signed [ACC_WIDTH-1:0] base,
   output logic signed [ACC_WIDTH-1:0] sum
);

   localparam int P_WIDTH = A_WIDTH + foccl_pkg::B_WIDTH;

   logic signed [P_WIDTH-1:0]   prod_ff;
   logic signed [ACC_WIDTH-1:0] acc_ff;
   logic signed [ACC_WIDTH-1:0] addend;
   logic signed [ACC_WIDTH-1:0] start;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (ctl.acc_en) begin
         acc_ff <= sum;
      end
   end

   always_comb begin
      addend = ACC_WIDTH'(prod_ff);
      start  = ctl.use_acc ? acc_ff : base;
      sum    = ctl.negate ? start - addend : start + addend;
   end

endmodule

// File: sv/foc_current_loop_top.sv
// ----------------------------------------------------------------------------
// FOC current loop top level
// Clarke, Park, two PI controllers, inverse Park and inverse Clarke per beat,
// computed on one shared multiply-accumulate unit under a step sequencer.
// ----------------------------------------------------------------------------
// The sequencer runs 27 steps on the shared multiplier, each a multiply phase
// followed by an accumulate phase, then loads the output register and raises
// the result handshake; a stalled output holds it in the drain state.
// Input is taken only in idle, so beats never overlap on the single multiplier.
// Reset clears the gains, both integrators and the last timestamp.
module foc_current_loop_top #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int INTEGRATOR_BITS  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // phase_a_current, phase_b_current, elec_angle, q_reference,
   // q_feedforward, d_reference, timestamp
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // phase_a_voltage, phase_b_voltage, phase_c_voltage, d_current_est,
   // q_current_est
   output logic [79:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int IB    = INTEGRATOR_BITS;
   localparam int A_W   = (IB > 44) ? IB - 8 : 36;
   localparam int B_W   = foccl_pkg::B_WIDTH;
   localparam int ACC_W = A_W + B_W + 2;
   localparam int QSH   = 16 - $clog2(SINE_TABLE_DEPTH);
   localparam logic [15:0] PHASE_MASK = 16'(~((1 << QSH) - 1));
   localparam logic signed [ACC_W-1:0] RND15 = ACC_W'(16384);
   localparam logic signed [ACC_W-1:0] RND12 = ACC_W'(2048);
   localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] S16_MIN = -ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] I_MAX = (ACC_W'(1) <<< (IB - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] I_MIN = -I_MAX - ACC_W'(1);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_type;

   typedef enum logic [4:0] {
      SIN_ZZ, SIN_KC, SIN_KB, SIN_Z,
      COS_ZZ, COS_KC, COS_KB, COS_Z,
      CLARKE, D_ALPHA, D_BETA, Q_BETA, Q_ALPHA,
      Q_EK, Q_ET, D_EK, D_ET, Q_VOLT, D_VOLT,
      IA_D, IA_Q, IB_D, IB_Q, VB_A, VB_B, VC_A, VC_B
   } step_type;

   state_type state_ff;
   step_type  step_ff;
   logic      phase_ff;
   logic      rsp_tvalid_ff;
   logic [79:0] rsp_tdata_ff;

   logic [15:0] q_kp_ff, q_ki_ff, d_kp_ff, d_ki_ff;
   logic signed [IB-1:0] q_integ_ff, d_integ_ff;
   logic [15:0] last_ts_ff;
   logic [15:0] ticks_ff;

   logic signed [15:0] ia_ff, ib_ff, qref_ff, qff_ff, dref_ff;
   logic [15:0] angle_ff;

   logic [15:0] z2_ff, t_ff;
   logic signed [15:0] sn_ff, cs_ff, dest_ff, qest_ff, vb_ff, vc_ff;
   logic signed [17:0] beta_ff;
   logic signed [A_W-1:0] tmp_ff, vq_ff, vd_ff, ialpha_ff, ibeta_ff;

   logic cos_sel;
   logic [15:0] ang, pq;
   logic [14:0] z;
   logic signed [17:0] eq, ed, clarke_in;
   foccl_pkg::mac_ctl_type ctl;
   logic signed [A_W-1:0] op_a;
   logic signed [B_W-1:0] op_b;
   logic signed [ACC_W-1:0] base, sum, sh12, sh13, sh14, sh15;
   logic signed [15:0] sat15, sine_val, va;
   logic signed [IB-1:0] integ_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      cos_sel  = (step_ff == COS_ZZ) || (step_ff == COS_KC) ||
                 (step_ff == COS_KB) || (step_ff == COS_Z);
      ang      = cos_sel ? angle_ff + foccl_pkg::QUARTER_TURN : angle_ff;
      pq       = ang & PHASE_MASK;
      z        = pq[14] ? 15'd16384 - {1'b0, pq[13:0]} : {1'b0, pq[13:0]};
      eq       = 18'(qref_ff) + 18'(qff_ff) - 18'(qest_ff);
      ed       = 18'(dref_ff) - 18'(dest_ff);
      clarke_in = 18'(ia_ff) + (18'(ib_ff) <<< 1);
      sh12     = sum >>> 12;
      sh13     = sum >>> 13;
      sh14     = sum >>> 14;
      sh15     = sum >>> 15;
      sat15    = (sh15 > S16_MAX) ? 16'sd32767 :
                 (sh15 < S16_MIN) ? -16'sd32768 : sh15[15:0];
      sine_val = (sh13 > S16_MAX) ? 16'sd32767 : sh13[15:0];
      if (pq[15]) begin
         sine_val = -sine_val;
      end
      integ_sat = (sum > I_MAX) ? I_MAX[IB-1:0] :
                  (sum < I_MIN) ? I_MIN[IB-1:0] : sum[IB-1:0];
      va = (ialpha_ff > A_W'(32767)) ? 16'sd32767 :
           (ialpha_ff < -A_W'(32768)) ? -16'sd32768 : ialpha_ff[15:0];
   end

   always_comb begin
      ctl.mul_en  = (state_ff == ST_RUN) && !phase_ff;
      ctl.acc_en  = (state_ff == ST_RUN) && phase_ff;
      ctl.use_acc = 1'b0;
      ctl.negate  = 1'b0;
      op_a = '0;
      op_b = '0;
      base = '0;
      unique case (step_ff)
         SIN_ZZ, COS_ZZ: begin
            op_a = A_W'($signed({1'b0, z}));
            op_b = B_W'($signed({1'b0, z}));
         end
         SIN_KC, COS_KC: begin
            op_a = A_W'($signed({1'b0, z2_ff}));
            op_b = B_W'($signed({1'b0, foccl_pkg::SIN_C}));
         end
         SIN_KB, COS_KB: begin
            op_a = A_W'($signed({1'b0, z2_ff}));
            op_b = B_W'($signed({1'b0, t_ff}));
         end
         SIN_Z, COS_Z: begin
            op_a = A_W'($signed({1'b0, z}));
            op_b = B_W'($signed({1'b0, t_ff}));
         end
         CLARKE: begin
            op_a = A_W'(clarke_in);
            op_b = B_W'($signed({1'b0, foccl_pkg::INV_SQRT3_Q15}));
            base = RND15;
         end
         D_ALPHA: begin
            op_a = A_W'(ia_ff);
            op_b = B_W'(cs_ff);
            base = RND15;
         end
         D_BETA: begin
            op_a = A_W'(beta_ff);
            op_b = B_W'(sn_ff);
            ctl.use_acc = 1'b1;
         end
         Q_BETA: begin
            op_a = A_W'(beta_ff);
            op_b = B_W'(cs_ff);
            base = RND15;
         end
         Q_ALPHA: begin
            op_a = A_W'(ia_ff);
            op_b = B_W'(sn_ff);
            ctl.use_acc = 1'b1;
            ctl.negate  = 1'b1;
         end
         Q_EK: begin
            op_a = A_W'(eq);
            op_b = B_W'($signed({1'b0, q_ki_ff}));
         end
         Q_ET: begin
            op_a = tmp_ff;
            op_b = B_W'($signed({1'b0, ticks_ff}));
            base = ACC_W'(q_integ_ff);
         end
         D_EK: begin
            op_a = A_W'(ed);
            op_b = B_W'($signed({1'b0, d_ki_ff}));
         end
         D_ET: begin
            op_a = tmp_ff;
            op_b = B_W'($signed({1'b0, ticks_ff}));
            base = ACC_W'(d_integ_ff);
         end
         Q_VOLT: begin
            op_a = A_W'(eq);
            op_b = B_W'($signed({1'b0, q_kp_ff}));
            base = ACC_W'(q_integ_ff) + RND12;
         end
         D_VOLT: begin
            op_a = A_W'(ed);
            op_b = B_W'($signed({1'b0, d_kp_ff}));
            base = ACC_W'(d_integ_ff) + RND12;
         end
         IA_D: begin
            op_a = vd_ff;
            op_b = B_W'(cs_ff);
            base = RND15;
         end
         IA_Q: begin
            op_a = vq_ff;
            op_b = B_W'(sn_ff);
            ctl.use_acc = 1'b1;
            ctl.negate  = 1'b1;
         end
         IB_D: begin
            op_a = vd_ff;
            op_b = B_W'(sn_ff);
            base = RND15;
         end
         IB_Q: begin
            op_a = vq_ff;
            op_b = B_W'(cs_ff);
            ctl.use_acc = 1'b1;
         end
         VB_A, VC_A: begin
            op_a = ialpha_ff;
            op_b = B_W'($signed({1'b0, foccl_pkg::HALF_Q15}));
            base = RND15;
            ctl.negate = 1'b1;
         end
         VB_B: begin
            op_a = ibeta_ff;
            op_b = B_W'($signed({1'b0, foccl_pkg::SQRT3_HALF_Q15}));
            ctl.use_acc = 1'b1;
         end
         VC_B: begin
            op_a = ibeta_ff;
            op_b = B_W'($signed({1'b0, foccl_pkg::SQRT3_HALF_Q15}));
            ctl.use_acc = 1'b1;
            ctl.negate  = 1'b1;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   foccl_mac #(
      .A_WIDTH   (A_W),
      .ACC_WIDTH (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctl   (ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .base  (base),
      .sum   (sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= SIN_ZZ;
         phase_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         q_kp_ff       <= '0;
         q_ki_ff       <= '0;
         d_kp_ff       <= '0;
         d_ki_ff       <= '0;
         q_integ_ff    <= '0;
         d_integ_ff    <= '0;
         last_ts_ff    <= '0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               foccl_pkg::CSR_Q_PROP:  q_kp_ff <= csr_wdata;
               foccl_pkg::CSR_Q_INTEG: q_ki_ff <= csr_wdata;
               foccl_pkg::CSR_D_PROP:  d_kp_ff <= csr_wdata;
               foccl_pkg::CSR_D_INTEG: d_ki_ff <= csr_wdata;
               default: q_kp_ff <= q_kp_ff;
            endcase
         end
         if (state_ff == ST_DRAIN && (!rsp_tvalid_ff || rsp_tready)) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  ia_ff      <= req_tdata[15:0];
                  ib_ff      <= req_tdata[31:16];
                  angle_ff   <= req_tdata[47:32];
                  qref_ff    <= req_tdata[63:48];
                  qff_ff     <= req_tdata[79:64];
                  dref_ff    <= req_tdata[95:80];
                  ticks_ff   <= req_tdata[111:96] - last_ts_ff;
                  last_ts_ff <= req_tdata[111:96];
                  step_ff    <= SIN_ZZ;
                  phase_ff   <= 1'b0;
                  state_ff   <= ST_RUN;
               end
            end
            ST_RUN: begin
               phase_ff <= !phase_ff;
               if (phase_ff) begin
                  unique case (step_ff)
                     SIN_ZZ, COS_ZZ: z2_ff <= sh14[15:0];
                     SIN_KC, COS_KC: t_ff <= foccl_pkg::SIN_B - sh14[15:0];
                     SIN_KB, COS_KB: t_ff <= foccl_pkg::SIN_A - sh14[15:0];
                     SIN_Z:   sn_ff <= sine_val;
                     COS_Z:   cs_ff <= sine_val;
                     CLARKE:  beta_ff <= sh15[17:0];
                     D_BETA:  dest_ff <= sat15;
                     Q_ALPHA: qest_ff <= sat15;
                     Q_EK, D_EK: tmp_ff <= sum[A_W-1:0];
                     Q_ET:    q_integ_ff <= integ_sat;
                     D_ET:    d_integ_ff <= integ_sat;
                     Q_VOLT:  vq_ff <= sh12[A_W-1:0];
                     D_VOLT:  vd_ff <= sh12[A_W-1:0];
                     IA_Q:    ialpha_ff <= sh15[A_W-1:0];
                     IB_Q:    ibeta_ff <= sh15[A_W-1:0];
                     VB_B:    vb_ff <= sat15;
                     VC_B:    vc_ff <= sat15;
                     default: tmp_ff <= tmp_ff;
                  endcase
                  if (step_ff == VC_B) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     step_ff <= step_type'(step_ff + 5'd1);
                  end
               end
            end
            ST_DRAIN: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= {qest_ff, dest_ff, vc_ff, vb_ff, va};
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_start: assert property (@(posedge clock) disable iff (reset)
      !reset && req_tvalid && req_tready |=>
         state_ff == ST_RUN && step_ff == SIN_ZZ && !phase_ff)
      else $error("sequencer did not start after an input beat");

   a_phase: assert property (@(posedge clock) disable iff (reset)
      !reset && state_ff == ST_RUN && !phase_ff |=> state_ff == ST_RUN && phase_ff)
      else $error("multiply phase not followed by accumulate phase");

   a_unload: assert property (@(posedge clock) disable iff (reset)
      !reset && state_ff == ST_DRAIN && (!rsp_tvalid_ff || rsp_tready) |=>
         rsp_tvalid_ff && state_ff == ST_IDLE)
      else $error("result was not presented when the output was free");

endmodule
